// File: design/assert_macros.svh
// Assertion macros shared by the design files.
// Each macro wraps one concurrent assertion clocked and reset by the given signals.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds.
`define ASSERT_IMPLIES(lbl, clk_sig, rst_n_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk_sig, rst_n_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/mcs_pkg.sv
// Package for the metronome click synthesizer: register indexes, reset values,
// default parameter values and the sine table entry function. No dependencies.
package mcs_pkg;

    localparam int BEATS_PER_BAR_DEF   = 4;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int MAX_CHANNELS        = 8;

    localparam logic [2:0] REG_SAMPLES_PER_BEAT   = 3'd0;
    localparam logic [2:0] REG_CLICK_LENGTH       = 3'd1;
    localparam logic [2:0] REG_TONE_INCREMENT     = 3'd2;
    localparam logic [2:0] REG_ENVELOPE_INCREMENT = 3'd3;
    localparam logic [2:0] REG_GAIN_Q15           = 3'd4;
    localparam logic [2:0] REG_CHANNEL_COUNT      = 3'd5;
    localparam logic [2:0] REG_BAR_COUNT          = 3'd6;

    localparam logic [23:0] RST_SAMPLES_PER_BEAT   = 24'd22050;
    localparam logic [23:0] RST_CLICK_LENGTH       = 24'd2205;
    localparam logic [31:0] RST_TONE_INCREMENT     = 32'd97391549;
    localparam logic [31:0] RST_ENVELOPE_INCREMENT = 32'd973921;
    localparam logic [15:0] RST_GAIN_Q15           = 16'd8192;
    localparam logic [3:0]  RST_CHANNEL_COUNT      = 4'd2;
    localparam logic [15:0] RST_BAR_COUNT          = 16'd4;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // One quarter-wave entry from a Taylor series in Q30, scaled to 32767.
    // Only ever called with constant arguments, so it folds away at elaboration.
    function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (64'(k) * HALF_PI_Q30) >> qbits;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 64'd110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s * 64'd32767 + 64'd536870912) >> 30;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        return s[14:0];
    endfunction

endpackage

// File: design/mcs_sine_rom.sv
// Quarter-wave sine table with a registered read, addressed by a 32-bit phase.
// Depends on mcs_pkg for the table entry function.
module mcs_sine_rom #(
    parameter int SINE_TABLE_BITS = mcs_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic        clk,
    input  logic [31:0] phase,
    output logic [14:0] magnitude,
    output logic        negative
);

    localparam int QBITS   = SINE_TABLE_BITS - 2;
    localparam int QUARTER = 1 << QBITS;
    localparam int ADDR_W  = SINE_TABLE_BITS - 1;

    logic [14:0] rom [QUARTER + 1];

    for (genvar k = 0; k <= QUARTER; k++)
    begin : g_rom
        assign rom[k] = mcs_pkg::sine_entry(k, QBITS);
    end

    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad;
    logic [QBITS-1:0]           k_sel;
    logic [ADDR_W-1:0]          addr;
    logic [14:0]                magnitude_reg;
    logic                       negative_reg;

    assign idx   = phase[31 -: SINE_TABLE_BITS];
    assign quad  = idx[SINE_TABLE_BITS-1 -: 2];
    assign k_sel = idx[QBITS-1:0];

    // Odd quadrants run the table backward.
    assign addr = quad[0] ? (ADDR_W'(QUARTER) - {1'b0, k_sel}) : {1'b0, k_sel};

    always_ff @(posedge clk)
    begin
        magnitude_reg <= rom[addr];
        negative_reg  <= quad[1];
    end

    assign magnitude = magnitude_reg;
    assign negative  = negative_reg;

endmodule

// File: design/metronome_click_synth.sv
// Metronome click synthesizer top level: configuration registers, frame counters,
// sequencer with a shared multiplier, and the per-channel output stage.
// Depends on mcs_pkg, mcs_sine_rom and assert_macros.svh.

// Each accepted frame goes from its transfer until its sample is loaded for
// output through two reads of the single sine table port (tone, then envelope
// cosine), three passes through one shared 32 x 17 multiplier and rounding,
// which waits while the output stage is busy. The sample then leaves as one
// transfer per channel, one per cycle unless out_stall holds it, starting in
// the next cycle, while the next frame is already being computed. The input is
// stalled for the whole computation, until the sample is loaded for output.
// Configuration may be written only while no frame is in flight.
module metronome_click_synth #(
    parameter int BEATS_PER_BAR   = mcs_pkg::BEATS_PER_BAR_DEF,
    parameter int SINE_TABLE_BITS = mcs_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pcm_sample,
    output logic [2:0]         channel_index,
    output logic               last_of_frame,
    output logic               accent_beat,
    output logic               render_done
);

    localparam int BEAT_W = (BEATS_PER_BAR > 1) ? $clog2(BEATS_PER_BAR) : 1;
    localparam logic [BEAT_W:0] BEAT_LAST = (BEAT_W + 1)'(BEATS_PER_BAR - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK_T = 3'd1;
    localparam logic [2:0] S_LOOK_E = 3'd2;
    localparam logic [2:0] S_MUL1   = 3'd3;
    localparam logic [2:0] S_MUL2   = 3'd4;
    localparam logic [2:0] S_MUL3   = 3'd5;
    localparam logic [2:0] S_ROUND  = 3'd6;

    // Configuration registers.
    logic [23:0] samples_per_beat_reg;
    logic [23:0] click_length_reg;
    logic [31:0] tone_increment_reg;
    logic [31:0] envelope_increment_reg;
    logic [15:0] gain_q15_reg;
    logic [3:0]  channel_count_reg;
    logic [15:0] bar_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_per_beat_reg   <= mcs_pkg::RST_SAMPLES_PER_BEAT;
            click_length_reg       <= mcs_pkg::RST_CLICK_LENGTH;
            tone_increment_reg     <= mcs_pkg::RST_TONE_INCREMENT;
            envelope_increment_reg <= mcs_pkg::RST_ENVELOPE_INCREMENT;
            gain_q15_reg           <= mcs_pkg::RST_GAIN_Q15;
            channel_count_reg      <= mcs_pkg::RST_CHANNEL_COUNT;
            bar_count_reg          <= mcs_pkg::RST_BAR_COUNT;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                mcs_pkg::REG_SAMPLES_PER_BEAT:   samples_per_beat_reg   <= cfg_data[23:0];
                mcs_pkg::REG_CLICK_LENGTH:       click_length_reg       <= cfg_data[23:0];
                mcs_pkg::REG_TONE_INCREMENT:     tone_increment_reg     <= cfg_data;
                mcs_pkg::REG_ENVELOPE_INCREMENT: envelope_increment_reg <= cfg_data;
                mcs_pkg::REG_GAIN_Q15:           gain_q15_reg           <= cfg_data[15:0];
                mcs_pkg::REG_CHANNEL_COUNT:      channel_count_reg      <= cfg_data[3:0];
                mcs_pkg::REG_BAR_COUNT:          bar_count_reg          <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer and datapath registers.
    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [23:0]       frame_in_beat_reg;
    logic [BEAT_W-1:0] beat_in_bar_reg;
    logic [15:0]       bar_position_reg;
    logic [31:0]       tone_phase_reg;
    logic [31:0]       envelope_phase_reg;
    logic [14:0]       sine_mag_reg;
    logic              sine_neg_reg;
    logic [48:0]       prod_reg;

    logic              out_busy_reg;
    logic [2:0]        channel_reg;
    logic [2:0]        last_channel_reg;
    logic signed [15:0] pcm_reg;
    logic              accent_reg;
    logic              done_reg;

    logic in_xfer;
    logic out_xfer;
    logic load_out;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_busy_reg && !out_stall;
    assign load_out = (state_reg == S_ROUND) && !out_busy_reg;

    // Shared sine table port: tone phase first, then the envelope phase shifted
    // by a quarter turn to give the cosine.
    logic [31:0] rom_phase;
    logic [14:0] rom_mag;
    logic        rom_neg;

    assign rom_phase = (state_reg == S_LOOK_T) ? tone_phase_reg
                                               : (envelope_phase_reg + 32'h4000_0000);

    mcs_sine_rom #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_rom (
        .clk      (clk),
        .phase    (rom_phase),
        .magnitude(rom_mag),
        .negative (rom_neg)
    );

    // Envelope (32767 - cos) / 2 from the cosine read.
    logic [16:0] env_sum;
    logic [14:0] env_val;
    logic        accent_now;

    assign env_sum    = rom_neg ? (17'd32767 + {2'b00, rom_mag})
                                : (17'd32767 - {2'b00, rom_mag});
    assign env_val    = env_sum[15:1];
    assign accent_now = (beat_in_bar_reg == '0);

    logic [16:0] gain_sat;
    assign gain_sat = (gain_q15_reg > 16'd32768) ? 17'd32768 : {1'b0, gain_q15_reg};

    // One multiplier, used three times: env * accent, then * |sine|, then * gain.
    logic [31:0] mul_a;
    logic [16:0] mul_b;
    logic [48:0] mul_p;

    always_comb
    begin
        mul_a = prod_reg[31:0];
        mul_b = gain_sat;
        case (state_reg)
            S_MUL1:
            begin
                mul_a = {17'd0, env_val};
                mul_b = accent_now ? 17'd4 : 17'd3;
            end
            S_MUL2:
            begin
                mul_b = {2'b00, sine_mag_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign mul_p = {17'd0, mul_a} * {32'd0, mul_b};

    // Round half away from zero on the magnitude, then saturate.
    logic [49:0] round_sum;
    logic [17:0] round_mag;
    logic [14:0] sat_mag;
    logic        in_click;
    logic signed [15:0] pcm_calc;

    assign round_sum = {1'b0, prod_reg} + 50'h0_8000_0000;
    assign round_mag = round_sum[49:32];
    assign sat_mag   = (round_mag > 18'd32767) ? 15'h7FFF : round_mag[14:0];
    assign in_click  = (frame_in_beat_reg < click_length_reg);
    assign pcm_calc  = !in_click ? 16'sd0
                     : (sine_neg_reg ? -$signed({1'b0, sat_mag}) : $signed({1'b0, sat_mag}));

    // Beat, bar and render ends.
    logic [24:0] frame_plus;
    logic [16:0] bar_plus;
    logic        beat_end;
    logic        bar_end;
    logic        done_now;

    assign frame_plus = {1'b0, frame_in_beat_reg} + 25'd1;
    assign bar_plus   = {1'b0, bar_position_reg} + 17'd1;
    assign beat_end   = (frame_plus >= {1'b0, samples_per_beat_reg});
    assign bar_end    = beat_end && ({1'b0, beat_in_bar_reg} >= BEAT_LAST);
    assign done_now   = bar_end && (bar_plus >= {1'b0, bar_count_reg});

    logic [3:0] chans;
    always_comb
    begin
        if (channel_count_reg == 4'd0)
        begin
            chans = 4'd1;
        end
        else if (channel_count_reg > 4'(mcs_pkg::MAX_CHANNELS))
        begin
            chans = 4'(mcs_pkg::MAX_CHANNELS);
        end
        else
        begin
            chans = channel_count_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_xfer) state_next = S_LOOK_T;
            S_LOOK_T: state_next = S_LOOK_E;
            S_LOOK_E: state_next = S_MUL1;
            S_MUL1:   state_next = S_MUL2;
            S_MUL2:   state_next = S_MUL3;
            S_MUL3:   state_next = S_ROUND;
            S_ROUND:  if (load_out) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            frame_in_beat_reg  <= '0;
            beat_in_bar_reg    <= '0;
            bar_position_reg   <= '0;
            tone_phase_reg     <= '0;
            envelope_phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer && restart)
            begin
                frame_in_beat_reg  <= '0;
                beat_in_bar_reg    <= '0;
                bar_position_reg   <= '0;
                tone_phase_reg     <= '0;
                envelope_phase_reg <= '0;
            end
            else if (load_out)
            begin
                if (beat_end)
                begin
                    frame_in_beat_reg  <= '0;
                    tone_phase_reg     <= '0;
                    envelope_phase_reg <= '0;
                    if (bar_end)
                    begin
                        beat_in_bar_reg  <= '0;
                        bar_position_reg <= done_now ? 16'd0 : bar_plus[15:0];
                    end
                    else
                    begin
                        beat_in_bar_reg <= beat_in_bar_reg + 1'b1;
                    end
                end
                else
                begin
                    frame_in_beat_reg  <= frame_plus[23:0];
                    tone_phase_reg     <= tone_phase_reg + tone_increment_reg;
                    envelope_phase_reg <= envelope_phase_reg + envelope_increment_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOOK_E)
        begin
            sine_mag_reg <= rom_mag;
            sine_neg_reg <= rom_neg;
        end
        if ((state_reg == S_MUL1) || (state_reg == S_MUL2) || (state_reg == S_MUL3))
        begin
            prod_reg <= mul_p;
        end
        if (load_out)
        begin
            pcm_reg          <= pcm_calc;
            accent_reg       <= accent_now;
            done_reg         <= done_now;
            last_channel_reg <= 3'(chans - 4'd1);
        end
    end

    // Output stage: one transfer per channel of the held sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_busy_reg <= 1'b0;
            channel_reg  <= '0;
        end
        else if (load_out)
        begin
            out_busy_reg <= 1'b1;
            channel_reg  <= '0;
        end
        else if (out_xfer)
        begin
            if (channel_reg == last_channel_reg)
            begin
                out_busy_reg <= 1'b0;
            end
            else
            begin
                channel_reg <= channel_reg + 3'd1;
            end
        end
    end

    assign out_valid     = out_busy_reg;
    assign pcm_sample    = pcm_reg;
    assign channel_index = channel_reg;
    assign last_of_frame = (channel_reg == last_channel_reg);
    assign accent_beat   = accent_reg;
    assign render_done   = done_reg;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_xfer, state_reg == S_LOOK_T)
    `ASSERT_NEXT(a_frame_continues, clk, rst_n, out_xfer && !last_of_frame, out_valid)
    `ASSERT_IMPLIES(a_pcm_symmetric, clk, rst_n, out_valid, pcm_sample != 16'sh8000)
    `ASSERT_IMPLIES(a_channel_bound, clk, rst_n, out_valid, channel_reg <= last_channel_reg)

endmodule
